>>> hdl/sliding_window_packet_scheduler_macros.svh
// Assertion macros for the sliding window packet scheduler.
`ifndef SLIDING_WINDOW_PACKET_SCHEDULER_MACROS_SVH
`define SLIDING_WINDOW_PACKET_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SWPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define SWPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SWPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SWPS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/swps_pkg.sv
// Shared types, codes and constants of the sliding window packet scheduler.
`timescale 1ns / 1ps
`default_nettype none
package swps_pkg;

    localparam int MAX_WINDOW_DEF = 64;

    localparam int IDX_W     = 32;
    localparam int CNT_W     = 13;
    localparam int WIN_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 80;

    localparam logic [CNT_W-1:0] PKT_MAX = 13'd4096;
    localparam logic [CNT_W-1:0] PKT_RST = 13'd64;
    localparam logic [WIN_W-1:0] WIN_RST = 7'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PKT_ELEMS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INSTANT   = 2'd2;

    // input command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_RETURN = 1'b1;

    // result kind codes
    localparam logic KIND_DESC = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_MUL,
        ST_EMIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;     // capture accepted input transfer
        logic div_start;   // start packet count division
        logic div_load;    // latch slice totals, open burst
        logic ret_step;    // count a return, set refill index
        logic mul;         // form element offset of current index
        logic emit_desc;   // write descriptor to output register
        logic next_burst;  // advance burst index
        logic emit_done;   // write completion to output register
    } t_dp_cmd;

    typedef struct packed {
        logic cmd;         // command of captured item
        logic elems_zero;  // captured slice is empty
        logic instant;     // instant completion mode
        logic refill;      // returned index plus window is below total
        logic next_done;   // this return completes the slice
        logic recv_done;   // every packet received
        logic burst_last;  // current burst packet is the final one
        logic div_done;    // division finished
        logic out_free;    // output register can take a result
    } t_dp_sts;

endpackage
`default_nettype wire

>>> hdl/sliding_window_packet_scheduler.sv
// Sliding window packet scheduler: top level joining controller and datapath.
//
// Input stream (s side): tuser is the command (start slice / packet returned),
// tdata carries slice_elems in [31:0] and returned_index in [63:32].
// Output stream (m side): tuser is the result kind (descriptor / completion),
// tlast marks the final result of one input transfer, tdata carries
// pkt_index [31:0], packet_count [44:32], elem_offset [76:45].
// Configuration: write enable, index (0 packet size, 1 window, 2 instant
// mode) and data; a write takes effect at the clock edge it is seen.
// Timing: one item is handled at a time; tready is high only when the
// controller is idle. A refilling return passes through capture, decode,
// offset multiply and result write, then a completion write when it also
// completes the slice; a return that refills nothing skips the multiply and write.
// A start runs a bit-serial ceil division, then a multiply and a write per
// descriptor, for min(W, packets) descriptors in all.
// Instant or empty slices go to the completion write; ignored items go idle.
// A single output register sits on the m side; while the receiver stalls,
// the controller holds in its write state and nothing is lost.
// Reset (synchronous, active low) restores the configuration defaults
// and drops any slice in progress; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_packet_scheduler_macros.svh"
module sliding_window_packet_scheduler #(
    parameter int MAX_WINDOW = swps_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [swps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [swps_pkg::CFG_W-1:0]      i_cfg_data,
    // input stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [swps_pkg::S_DATA_W-1:0]   i_s_tdata,  // slice_elems, returned_index
    input  wire logic                            i_s_tuser,  // cmd
    // result stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [swps_pkg::M_DATA_W-1:0]        o_m_tdata,  // pkt_index, packet_count,
                                                             // elem_offset, zero pad
    output logic                                 o_m_tuser,  // kind
    output logic                                 o_m_tlast   // last
);
    import swps_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // controller: owns the handshake on the input side and the active flag
    swps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: config registers, divider, counters, multiplier, output register
    swps_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

    // results are written only into a free output register
    `SWPS_ASSERT_IMP(a_write_free, i_clk, i_rst_n, w_cmd.emit_desc || w_cmd.emit_done, w_sts.out_free)
    // one item at a time: ready drops right after a transfer
    `SWPS_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    // the divider never finishes the cycle after it starts
    `SWPS_ASSERT_NXT(a_div_span, i_clk, i_rst_n, w_cmd.div_start, !w_sts.div_done)
    // a completion is always the final result of its item
    `SWPS_ASSERT_IMP(a_done_last, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == KIND_DONE), o_m_tlast)

endmodule
`default_nettype wire

>>> hdl/swps_div.sv
// Radix-2 restoring divider giving ceil(dividend / divisor), one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module swps_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [swps_pkg::IDX_W-1:0]  i_dividend,
    input  wire logic [swps_pkg::CNT_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [swps_pkg::IDX_W-1:0]       o_ceil
);
    import swps_pkg::*;

    localparam int STEP_W = $clog2(IDX_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [IDX_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;

    logic [CNT_W:0]    w_trial;
    logic              w_ge;
    logic [CNT_W:0]    w_diff;

    assign w_trial = {r_rem, r_q[IDX_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(IDX_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[IDX_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
        end
    end

    // divisor >= 1, so a nonzero remainder never carries past 32 bits
    assign o_done = r_done;
    assign o_ceil = r_q + IDX_W'(r_rem != '0);

endmodule
`default_nettype wire

>>> hdl/swps_dp.sv
// Datapath: configuration, slice counters, offset multiplier and output register.
`timescale 1ns / 1ps
`default_nettype none
module swps_dp #(
    parameter int MAX_WINDOW = swps_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [swps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [swps_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic [swps_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  wire logic                            i_s_tuser,
    input  wire logic                            i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [swps_pkg::M_DATA_W-1:0]        o_m_tdata,
    output logic                                 o_m_tuser,
    output logic                                 o_m_tlast,
    input  wire swps_pkg::t_dp_cmd               i_cmd,
    output swps_pkg::t_dp_sts                    o_sts
);
    import swps_pkg::*;

    localparam int BURST_W = $clog2(MAX_WINDOW + 1);
    localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_WINDOW);
    localparam int PROD_W = IDX_W + CNT_W;

    // configuration
    logic [CNT_W-1:0]   r_pkt_elems;
    logic [WIN_W-1:0]   r_window;
    logic               r_instant;

    // captured item
    logic               r_cmd;
    logic [IDX_W-1:0]   r_in_elems;
    logic [IDX_W-1:0]   r_ret_idx;

    // slice state
    logic [IDX_W-1:0]   r_slice_elems;
    logic [IDX_W-1:0]   r_total;
    logic [IDX_W-1:0]   r_recv;
    logic [IDX_W-1:0]   r_idx;
    logic [BURST_W-1:0] r_burst_left;
    logic [PROD_W-1:0]  r_prod;

    // output register
    logic               r_out_valid;
    logic               r_out_kind;
    logic [IDX_W-1:0]   r_out_idx;
    logic [CNT_W-1:0]   r_out_cnt;
    logic [IDX_W-1:0]   r_out_off;
    logic               r_out_last;

    logic [CNT_W-1:0]   w_pkt;
    logic [WIN_W-1:0]   w_win;
    logic               w_div_done;
    logic [IDX_W-1:0]   w_ceil;
    logic [IDX_W:0]     w_next;
    logic [IDX_W-1:0]   w_recv_inc;
    logic               w_in_slice;
    logic [IDX_W-1:0]   w_rest;
    logic [CNT_W-1:0]   w_cnt;
    logic               w_out_free;
    logic               w_burst_last;
    logic [BURST_W-1:0] w_burst_len;

    // effective packet size and window
    always_comb begin
        if (r_pkt_elems == '0) begin
            w_pkt = CNT_W'(1);
        end else if (r_pkt_elems > PKT_MAX) begin
            w_pkt = PKT_MAX;
        end else begin
            w_pkt = r_pkt_elems;
        end
        if (r_window == '0) begin
            w_win = WIN_W'(1);
        end else if (r_window > WIN_MAX) begin
            w_win = WIN_MAX;
        end else begin
            w_win = r_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_elems <= PKT_RST;
            r_window    <= WIN_RST;
            r_instant   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PKT_ELEMS: r_pkt_elems <= i_cfg_data;
                CFG_WINDOW:    r_window    <= i_cfg_data[WIN_W-1:0];
                CFG_INSTANT:   r_instant   <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd      <= i_s_tuser;
            r_in_elems <= i_s_tdata[IDX_W-1:0];
            r_ret_idx  <= i_s_tdata[2*IDX_W-1:IDX_W];
        end
    end

    swps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_in_elems),
        .i_divisor  (w_pkt),
        .o_done     (w_div_done),
        .o_ceil     (w_ceil)
    );

    assign w_next      = {1'b0, r_ret_idx} + (IDX_W + 1)'(w_win);
    assign w_recv_inc  = r_recv + IDX_W'(1);
    assign w_burst_len = (w_ceil < IDX_W'(w_win)) ? BURST_W'(w_ceil) : BURST_W'(w_win);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_elems <= '0;
            r_total       <= '0;
            r_recv        <= '0;
        end else if (i_cmd.div_load) begin
            r_slice_elems <= r_in_elems;
            r_total       <= w_ceil;
            r_recv        <= '0;
        end else if (i_cmd.ret_step) begin
            r_recv        <= w_recv_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_idx        <= '0;
            r_burst_left <= w_burst_len;
        end else if (i_cmd.ret_step) begin
            r_idx        <= w_next[IDX_W-1:0];
        end else if (i_cmd.next_burst) begin
            r_idx        <= r_idx + IDX_W'(1);
            r_burst_left <= r_burst_left - BURST_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= r_idx * w_pkt;
        end
    end

    // packet start must lie inside the slice; count is the rest, capped at P
    assign w_in_slice   = r_prod < PROD_W'(r_slice_elems);
    assign w_rest       = r_slice_elems - r_prod[IDX_W-1:0];
    assign w_cnt        = (w_rest < IDX_W'(w_pkt)) ? w_rest[CNT_W-1:0] : w_pkt;
    assign w_out_free   = !r_out_valid || i_m_tready;
    assign w_burst_last = r_burst_left == BURST_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.emit_desc && w_in_slice) || i_cmd.emit_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_done) begin
            r_out_kind <= KIND_DONE;
            r_out_idx  <= '0;
            r_out_cnt  <= '0;
            r_out_off  <= '0;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit_desc && w_in_slice) begin
            r_out_kind <= KIND_DESC;
            r_out_idx  <= r_idx;
            r_out_cnt  <= w_cnt;
            r_out_off  <= r_prod[IDX_W-1:0];
            r_out_last <= (r_cmd == CMD_START) ? w_burst_last : !(r_recv >= r_total);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_DATA_W - 2*IDX_W - CNT_W)'(0), r_out_off, r_out_cnt, r_out_idx};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.elems_zero = r_in_elems == '0;
        o_sts.instant    = r_instant;
        o_sts.refill     = w_next < {1'b0, r_total};
        o_sts.next_done  = w_recv_inc >= r_total;
        o_sts.recv_done  = r_recv >= r_total;
        o_sts.burst_last = w_burst_last;
        o_sts.div_done   = w_div_done;
        o_sts.out_free   = w_out_free;
    end

endmodule
`default_nettype wire

>>> hdl/swps_ctrl.sv
// Controller state machine: sequences decode, division, offset and result writes.
`timescale 1ns / 1ps
`default_nettype none
module swps_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire swps_pkg::t_dp_sts  i_sts,
    output swps_pkg::t_dp_cmd       o_cmd
);
    import swps_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_active;
    logic   n_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_sts.cmd == CMD_START) begin
                    if (r_active) begin
                        n_state = ST_IDLE;
                    end else if (i_sts.instant || i_sts.elems_zero) begin
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end
                end else if (!r_active) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.ret_step = 1'b1;
                    if (i_sts.refill) begin
                        n_state = ST_MUL;
                    end else if (i_sts.next_done) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_active       = 1'b1;
                    n_state        = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_desc = 1'b1;
                    if (i_sts.cmd == CMD_START) begin
                        if (i_sts.burst_last) begin
                            n_state = ST_IDLE;
                        end else begin
                            o_cmd.next_burst = 1'b1;
                            n_state          = ST_MUL;
                        end
                    end else if (i_sts.recv_done) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_active        = 1'b0;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
